FILE: design/spg_pkg.sv
// Shared types and constants for the step/direction pulse generator.
// No dependencies; compiled before the interfaces and the core.
package spg_pkg;

  // Item operation codes
  typedef logic [1:0] func_t;
  localparam func_t FUNC_TICK  = 2'd0;
  localparam func_t FUNC_MOVE  = 2'd1;
  localparam func_t FUNC_STOP  = 2'd2;
  localparam func_t FUNC_TAKE  = 2'd3;

  // Payload widths fixed by the item format
  localparam int unsigned FREQ_BITS  = 20;
  localparam int unsigned WORD_BITS  = 32;

  // Defaults for the core parameters
  localparam int unsigned DEF_TIMER_CLK_HZ = 1000000;
  localparam int unsigned DEF_COUNT_BITS   = 20;

  // Step period after reset, in timer clocks
  localparam int unsigned RESET_PERIOD = 2500;

endpackage

FILE: design/spg_if.sv
// Valid/ready channel interfaces for the pulse generator command and status items.
// Depends on spg_pkg for the operation code type and field widths.
interface spg_in_if;
  logic                             valid;
  logic                             ready;
  spg_pkg::func_t                   func;
  logic                             dir_positive;
  logic [spg_pkg::WORD_BITS-1:0]    pulse_count;
  logic [spg_pkg::FREQ_BITS-1:0]    frequency_hz;

  modport source (output valid, output func, output dir_positive, output pulse_count,
                  output frequency_hz, input ready);
  modport sink   (input valid, input func, input dir_positive, input pulse_count,
                  input frequency_hz, output ready);
endinterface

interface spg_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 step_level;
  logic                                 dir_level;
  logic                                 busy_res;
  logic [spg_pkg::WORD_BITS-1:0]        remaining_pulses;
  logic [spg_pkg::WORD_BITS-1:0]        completed_pulses;
  logic signed [spg_pkg::WORD_BITS-1:0] position_total;
  logic                                 completion_event;

  modport source (output valid, output step_level, output dir_level, output busy_res,
                  output remaining_pulses, output completed_pulses, output position_total,
                  output completion_event, input ready);
  modport sink   (input valid, input step_level, input dir_level, input busy_res,
                  input remaining_pulses, input completed_pulses, input position_total,
                  input completion_event, output ready);
endinterface

FILE: design/step_pulse_train_generator_core.sv
// Step/direction pulse generator core: command decode, period divider and step timing.
// Depends on spg_pkg and the channel interfaces in spg_if.sv.
//
// Every item returns one status item showing the state after it. Tick, stop and take
// items are accepted back to back as long as the status side takes every item. For a
// move item the step period TIMER_CLK_HZ / frequency_hz comes from a restoring divider
// over DIV_BITS dividend bits, where DIV_BITS is the bit length of TIMER_CLK_HZ, that
// retires one quotient bit per cycle, and no item is accepted while it runs. The
// period is held within 1 .. 2^COUNT_BITS-1 timer clocks. A tick item is one timer
// clock; step_level is high for the second half of each period while a move is busy.
module step_pulse_train_generator_core #(
  parameter int unsigned TIMER_CLK_HZ = spg_pkg::DEF_TIMER_CLK_HZ,
  parameter int unsigned COUNT_BITS   = spg_pkg::DEF_COUNT_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  spg_in_if.sink    in_ch,
  spg_out_if.source out_ch
);
  import spg_pkg::*;

  localparam int DIV_BITS  = $clog2(TIMER_CLK_HZ + 1);
  localparam int ITER_BITS = $clog2(DIV_BITS + 1);
  localparam int QW        = (DIV_BITS > COUNT_BITS) ? DIV_BITS : COUNT_BITS;
  localparam int REM_BITS  = FREQ_BITS + 1;
  localparam int SUM_BITS  = WORD_BITS + 2;

  localparam logic [DIV_BITS-1:0]   DIVIDEND   = DIV_BITS'(TIMER_CLK_HZ);
  localparam logic [QW-1:0]         CNT_MAX    = QW'({COUNT_BITS{1'b1}});
  localparam logic [QW-1:0]         Q_ONE      = QW'(1);
  localparam logic [COUNT_BITS-1:0] RST_PERIOD = COUNT_BITS'(RESET_PERIOD);
  localparam logic [COUNT_BITS-1:0] CNT_ONE    = COUNT_BITS'(1);
  localparam logic [ITER_BITS-1:0]  LAST_ITER  = ITER_BITS'(DIV_BITS - 1);
  localparam logic [ITER_BITS-1:0]  ITER_ONE   = ITER_BITS'(1);
  localparam logic [FREQ_BITS-1:0]  FREQ_ONE   = FREQ_BITS'(1);
  localparam logic [WORD_BITS-1:0]  WORD_ONE   = WORD_BITS'(1);
  localparam logic signed [SUM_BITS-1:0] SUM_MAX = SUM_BITS'(64'sd2147483647);
  localparam logic signed [SUM_BITS-1:0] SUM_MIN = SUM_BITS'(-64'sd2147483648);

  // Sequencer states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic                        state_r, state_nxt;
  logic [ITER_BITS-1:0]        iter_r, iter_nxt;
  logic [DIV_BITS-1:0]         dq_r, dq_nxt;
  logic [FREQ_BITS-1:0]        rem_r, rem_nxt;
  logic [FREQ_BITS-1:0]        divisor_r, divisor_nxt;

  logic [WORD_BITS-1:0]        remaining_r, remaining_nxt;
  logic [WORD_BITS-1:0]        completed_r, completed_nxt;
  logic signed [WORD_BITS-1:0] total_r, total_nxt;
  logic [COUNT_BITS-1:0]       period_r, period_nxt;
  logic [COUNT_BITS-1:0]       half_r, half_nxt;
  logic [COUNT_BITS-1:0]       count_r, count_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic                        dir_r, dir_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic                        event_r, event_nxt;

  logic                        in_fire;
  logic                        emit;
  logic [REM_BITS-1:0]         rem_sh;
  logic [REM_BITS-1:0]         diff;
  logic                        qbit;
  logic [DIV_BITS-1:0]         dq_step;
  logic [QW-1:0]               q_ext;
  logic [QW-1:0]               q_clamp;
  logic [COUNT_BITS-1:0]       period_q;
  logic signed [SUM_BITS-1:0]  total_ext;
  logic signed [SUM_BITS-1:0]  pulses_ext;
  logic signed [SUM_BITS-1:0]  sum;
  logic signed [WORD_BITS-1:0] total_sat;
  logic [WORD_BITS-1:0]        remaining_dec;

  // Accept while no divide runs and the status register is free or draining
  assign in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // One restoring divide step: shift in the next dividend bit, try the subtract
  assign rem_sh  = {rem_r, dq_r[DIV_BITS-1]};
  assign diff    = rem_sh - {1'b0, divisor_r};
  assign qbit    = !diff[REM_BITS-1];
  assign dq_step = {dq_r[DIV_BITS-2:0], qbit};

  // Hold the quotient within the counter range
  assign q_ext    = QW'(dq_step);
  assign q_clamp  = (q_ext == '0) ? Q_ONE : ((q_ext > CNT_MAX) ? CNT_MAX : q_ext);
  assign period_q = q_clamp[COUNT_BITS-1:0];

  // Saturating position update for a move
  assign total_ext  = SUM_BITS'(total_r);
  assign pulses_ext = $signed({2'b00, in_ch.pulse_count});
  assign sum        = in_ch.dir_positive ? (total_ext + pulses_ext)
                                         : (total_ext - pulses_ext);
  assign total_sat  = (sum > SUM_MAX) ? WORD_BITS'(SUM_MAX)
                    : ((sum < SUM_MIN) ? WORD_BITS'(SUM_MIN) : sum[WORD_BITS-1:0]);

  assign remaining_dec = remaining_r - WORD_ONE;

  // Next-state logic for commands, ticks and the divider sequencer
  always_comb begin
    state_nxt     = state_r;
    iter_nxt      = iter_r;
    dq_nxt        = dq_r;
    rem_nxt       = rem_r;
    divisor_nxt   = divisor_r;
    remaining_nxt = remaining_r;
    completed_nxt = completed_r;
    total_nxt     = total_r;
    period_nxt    = period_r;
    half_nxt      = half_r;
    count_nxt     = count_r;
    busy_nxt      = busy_r;
    done_nxt      = done_r;
    dir_nxt       = dir_r;
    event_nxt     = event_r;
    emit          = 1'b0;

    if (state_r == ST_DIV) begin
      // Advance the divider; commit the period on the last bit
      rem_nxt  = qbit ? diff[FREQ_BITS-1:0] : rem_sh[FREQ_BITS-1:0];
      dq_nxt   = dq_step;
      iter_nxt = iter_r + ITER_ONE;
      if (iter_r == LAST_ITER) begin
        period_nxt = period_q;
        half_nxt   = period_q >> 1;
        count_nxt  = period_q - CNT_ONE;
        state_nxt  = ST_IDLE;
        event_nxt  = 1'b0;
        emit       = 1'b1;
      end
    end else if (in_fire) begin
      unique case (in_ch.func)
        FUNC_TICK: begin
          event_nxt = 1'b0;
          emit      = 1'b1;
          if (busy_r) begin
            if (count_r == '0) begin
              count_nxt = period_r - CNT_ONE;
              if (remaining_r != '0) begin
                remaining_nxt = remaining_dec;
                completed_nxt = completed_r + WORD_ONE;
                if (remaining_dec == '0) begin
                  half_nxt = period_r;
                  busy_nxt = 1'b0;
                  done_nxt = 1'b1;
                end
              end
            end else begin
              count_nxt = count_r - CNT_ONE;
            end
          end
        end
        FUNC_MOVE: begin
          // Latch the move and launch the period divide
          dir_nxt       = in_ch.dir_positive;
          remaining_nxt = in_ch.pulse_count;
          busy_nxt      = 1'b1;
          done_nxt      = 1'b0;
          total_nxt     = total_sat;
          divisor_nxt   = (in_ch.frequency_hz == '0) ? FREQ_ONE : in_ch.frequency_hz;
          dq_nxt        = DIVIDEND;
          rem_nxt       = '0;
          iter_nxt      = '0;
          state_nxt     = ST_DIV;
        end
        FUNC_STOP: begin
          half_nxt      = period_r;
          remaining_nxt = '0;
          busy_nxt      = 1'b0;
          done_nxt      = 1'b0;
          event_nxt     = 1'b0;
          emit          = 1'b1;
        end
        FUNC_TAKE: begin
          event_nxt = done_r;
          done_nxt  = 1'b0;
          emit      = 1'b1;
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end

    // Hold the status item until taken
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      event_r     <= 1'b0;
      remaining_r <= '0;
      completed_r <= '0;
      total_r     <= '0;
      period_r    <= RST_PERIOD;
      half_r      <= RST_PERIOD;
      count_r     <= '0;
      busy_r      <= 1'b0;
      done_r      <= 1'b0;
      dir_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      event_r     <= event_nxt;
      remaining_r <= remaining_nxt;
      completed_r <= completed_nxt;
      total_r     <= total_nxt;
      period_r    <= period_nxt;
      half_r      <= half_nxt;
      count_r     <= count_nxt;
      busy_r      <= busy_nxt;
      done_r      <= done_nxt;
      dir_r       <= dir_nxt;
    end
  end

  // Divider datapath registers
  always_ff @(posedge clk) begin
    iter_r    <= iter_nxt;
    dq_r      <= dq_nxt;
    rem_r     <= rem_nxt;
    divisor_r <= divisor_nxt;
  end

  // State only changes on an accepted item or when a divide ends, so it holds while a status item waits
  assign out_ch.valid            = out_valid_r;
  assign out_ch.step_level       = busy_r && (count_r < half_r);
  assign out_ch.dir_level        = dir_r;
  assign out_ch.busy_res         = busy_r;
  assign out_ch.remaining_pulses = remaining_r;
  assign out_ch.completed_pulses = completed_r;
  assign out_ch.position_total   = total_r;
  assign out_ch.completion_event = event_r;

`ifndef SYNTHESIS
  a_no_accept_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> !in_ch.ready)
    else $error("item accepted during period divide");

  a_move_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_ch.func == FUNC_MOVE)) |=> ((state_r == ST_DIV) && !out_valid_r))
    else $error("move did not start the divider");

  a_half_within_period: assert property (@(posedge clk) disable iff (!rst_n)
    (half_r <= period_r) && (period_r != '0))
    else $error("half period above period or zero period");

  a_count_within_period: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (count_r < period_r))
    else $error("count beyond period");

  a_idle_no_remaining_on_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_ch.func == FUNC_STOP)) |=> (!busy_r && (remaining_r == '0) && !done_r))
    else $error("stop left the move running");
`endif

endmodule
